### hw/rtl/c8ie_pkg.sv
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types, codes and helpers for the chip-8 instruction execute block.
// ----------------------------------------------------------------------------
package c8ie_pkg;

  localparam int MemBytes     = 4096;
  localparam int ScreenWidth  = 64;
  localparam int ScreenHeight = 32;
  localparam int KeyCount     = 16;
  localparam int StackDepth   = 16;

  localparam int AddrW = $clog2(MemBytes);
  localparam int RowW  = $clog2(ScreenHeight);
  localparam int ColW  = $clog2(ScreenWidth);

  // command codes
  localparam logic [2:0] CMD_EXEC    = 3'd0;
  localparam logic [2:0] CMD_MEM_WR  = 3'd1;
  localparam logic [2:0] CMD_MEM_RD  = 3'd2;
  localparam logic [2:0] CMD_ROW_RD  = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;
  localparam logic [2:0] CMD_REG_RD  = 3'd5;

  // opcode groups (top nibble)
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDIX = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  // 8xyN sub codes
  localparam logic [3:0] SUB_MOV = 4'h0;
  localparam logic [3:0] SUB_OR  = 4'h1;
  localparam logic [3:0] SUB_AND = 4'h2;
  localparam logic [3:0] SUB_XOR = 4'h3;
  localparam logic [3:0] SUB_ADD = 4'h4;
  localparam logic [3:0] SUB_SUB = 4'h5;
  localparam logic [3:0] SUB_SHR = 4'h6;
  localparam logic [3:0] SUB_SBN = 4'h7;
  localparam logic [3:0] SUB_SHL = 4'hE;

  // Ex and Fx low byte codes
  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_GDT  = 8'h07;
  localparam logic [7:0] KK_WKEY = 8'h0A;
  localparam logic [7:0] KK_SDT  = 8'h15;
  localparam logic [7:0] KK_SST  = 8'h18;
  localparam logic [7:0] KK_ADDI = 8'h1E;
  localparam logic [7:0] KK_FONT = 8'h29;
  localparam logic [7:0] KK_BCD  = 8'h33;
  localparam logic [7:0] KK_STR  = 8'h55;
  localparam logic [7:0] KK_LDR  = 8'h65;

  typedef enum logic [3:0] {
    ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDX, ST_RDY, ST_EXEC, ST_DRAW_RD, ST_DRAW_WR,
    ST_BCD, ST_STORE, ST_LOAD_RD, ST_LOAD_WR, ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] instruction;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] key_state;
    logic [7:0]  random_byte;
  } in_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [11:0] index_value;
    logic [7:0]  read_data;
    logic [63:0] display_row;
    logic        waiting_for_key;
    logic        sound_active;
  } out_t;

  // hundreds, tens, ones of a byte by compare and subtract
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [7:0] r;
    logic [3:0] h;
    logic [3:0] t;
    begin
      h = 4'd0;
      r = v;
      if (r >= 8'd200) begin
        h = 4'd2;
        r = r - 8'd200;
      end else if (r >= 8'd100) begin
        h = 4'd1;
        r = r - 8'd100;
      end
      t = 4'd0;
      for (int k = 9; k >= 1; k--) begin
        if (t == 4'd0 && r >= 8'(k * 10)) t = 4'(k);
      end
      r = r - ({4'd0, t} * 8'd10);
      bcd_digits = {h, t, r[3:0]};
    end
  endfunction

endpackage

### hw/rtl/c8ie_ram.sv
// ----------------------------------------------------------------------------
// c8ie_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8ie_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/c8ie_alu.sv
// ----------------------------------------------------------------------------
// c8ie_alu
// Shared 8-bit arithmetic and logic unit with carry, not-borrow and shift flag.
// ----------------------------------------------------------------------------
module c8ie_alu (
  input  c8ie_pkg::alu_op_t op,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  output logic [7:0]        res,
  output logic              flag
);

  import c8ie_pkg::*;

  logic [8:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  // operation select
  always_comb begin
    res  = b;
    flag = 1'b0;
    case (op)
      ALU_PASS: res = b;
      ALU_OR:   res = a | b;
      ALU_AND:  res = a & b;
      ALU_XOR:  res = a ^ b;
      ALU_ADD: begin
        res  = sum[7:0];
        flag = sum[8];
      end
      ALU_SUB: begin
        res  = a - b;
        flag = (a >= b);
      end
      ALU_SHR: begin
        res  = {1'b0, a[7:1]};
        flag = a[0];
      end
      ALU_SHL: begin
        res  = {a[6:0], 1'b0};
        flag = a[7];
      end
      default: res = b;
    endcase
  end

endmodule

### hw/rtl/chip8_instruction_execute_top.sv
// Steps: every command passes read x, read y, execute and done; Dxyn adds a
// read and a write per sprite row, Fx33 a write per digit, Fx55 a write per
// register and Fx65 a read and a write per register, all paced by the one main
// memory port. One transaction at a time; the next is taken once the result is
// registered. Reset clears the registers, timers, stack pointer and the
// framebuffer row valid bits at once; main memory and the stack are not cleared.
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top
// CHIP-8 core: a small sequencer drives a shared ALU, the main memory and the
// framebuffer memory to run one command transaction at a time.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  c8ie_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output c8ie_pkg::out_t out_data
);

  import c8ie_pkg::*;

  state_t state_r, state_nxt;

  // latched transaction
  logic [2:0]  cmd_r;
  logic [15:0] op_r;
  logic [11:0] addr_r;
  logic [7:0]  wdata_r;
  logic [15:0] keys_r;
  logic [7:0]  rnd_r;

  // architectural state
  logic [7:0]       regs_r [16];
  logic [AddrW-1:0] pc_r;
  logic [AddrW-1:0] i_r;
  logic [3:0]       sp_r;
  logic [AddrW-1:0] stk_r [StackDepth];
  logic [7:0]       dt_r;
  logic [7:0]       st_r;
  logic [ScreenHeight-1:0] fb_valid_r;

  // working registers
  logic [7:0]  vx_r;
  logic [7:0]  vy_r;
  logic [3:0]  cnt_r;
  logic        hit_r;
  logic [7:0]  rd_r;
  logic [63:0] row_r;
  logic        wait_r;
  logic        out_valid_r;
  out_t        out_data_r;

  // decode fields
  logic [3:0]  op_hi, op_x, op_y, op_n;
  logic [7:0]  op_kk;
  logic [11:0] op_nnn;

  assign op_hi  = op_r[15:12];
  assign op_x   = op_r[11:8];
  assign op_y   = op_r[7:4];
  assign op_n   = op_r[3:0];
  assign op_kk  = op_r[7:0];
  assign op_nnn = op_r[11:0];

  // register file read port
  logic [3:0] rf_idx;
  logic [7:0] rf_rd;

  assign rf_rd = regs_r[rf_idx];

  // memories
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic             fb_we;
  logic [RowW-1:0]  fb_waddr, fb_raddr;
  logic [63:0]      fb_wdata, fb_rdata;

  c8ie_ram #(.Width(8), .Depth(MemBytes)) u_main_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  c8ie_ram #(.Width(ScreenWidth), .Depth(ScreenHeight)) u_frame_mem (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  // shared alu
  alu_op_t    alu_op;
  logic [7:0] alu_a, alu_b, alu_res;
  logic       alu_flag;

  c8ie_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .flag (alu_flag)
  );

  // sprite row geometry
  logic [AddrW-1:0]  i_plus_cnt;
  logic [RowW-1:0]   draw_row;
  logic [ColW-1:0]   draw_col;
  logic [127:0]      sprite_dbl;
  logic [63:0]       sprite_mask;
  logic [63:0]       row_cur;

  assign i_plus_cnt  = i_r + AddrW'(cnt_r);
  assign draw_row    = vy_r[RowW-1:0] + RowW'(cnt_r);
  assign draw_col    = vx_r[ColW-1:0];
  assign sprite_dbl  = {mem_rdata, 56'd0, mem_rdata, 56'd0} >> draw_col;
  assign sprite_mask = sprite_dbl[63:0];
  assign row_cur     = fb_valid_r[draw_row] ? fb_rdata : 64'd0;

  // lowest pressed key
  logic [3:0] key_idx;
  logic       key_any;

  always_comb begin
    key_idx = 4'd0;
    for (int k = KeyCount - 1; k >= 0; k--) begin
      if (keys_r[k]) key_idx = 4'(k);
    end
  end

  assign key_any = |keys_r;

  logic [11:0] bcd;
  logic        key_hit;

  assign bcd     = bcd_digits(vx_r);
  assign key_hit = keys_r[vx_r[3:0]];

  // pc for the execute step
  logic [AddrW-1:0] pc_inc, pc_skip, pc_exec;

  assign pc_inc  = pc_r + AddrW'(2);
  assign pc_skip = pc_r + AddrW'(4);

  always_comb begin
    pc_exec = pc_inc;
    case (op_hi)
      OP_SYS:  if (op_r == INS_RET) pc_exec = stk_r[sp_r - 4'd1];
      OP_JP:   pc_exec = op_nnn;
      OP_CALL: pc_exec = op_nnn;
      OP_SEI:  if (vx_r == op_kk) pc_exec = pc_skip;
      OP_SNEI: if (vx_r != op_kk) pc_exec = pc_skip;
      OP_SER:  if (op_n == 4'd0 && vx_r == vy_r) pc_exec = pc_skip;
      OP_SNER: if (op_n == 4'd0 && vx_r != vy_r) pc_exec = pc_skip;
      OP_JPV0: pc_exec = op_nnn + {4'd0, vy_r};
      OP_KEY: begin
        if ((op_kk == KK_SKP && key_hit) || (op_kk == KK_SKNP && !key_hit)) begin
          pc_exec = pc_skip;
        end
      end
      OP_MISC: if (op_kk == KK_WKEY && !key_any) pc_exec = pc_r;
      default: pc_exec = pc_inc;
    endcase
  end

  // register write decision
  logic       reg_we, flag_we, flag_val;
  logic [3:0] reg_widx;
  logic [7:0] reg_wdata;

  // sequencer: next state, read ports, memory writes, alu control
  always_comb begin
    state_nxt = state_r;
    rf_idx    = op_x;
    mem_we    = 1'b0;
    mem_waddr = i_plus_cnt;
    mem_wdata = 8'd0;
    mem_raddr = addr_r;
    fb_we     = 1'b0;
    fb_waddr  = draw_row;
    fb_wdata  = row_cur ^ sprite_mask;
    fb_raddr  = addr_r[RowW-1:0];
    alu_op    = ALU_PASS;
    alu_a     = vx_r;
    alu_b     = vy_r;
    reg_we    = 1'b0;
    reg_widx  = op_x;
    reg_wdata = alu_res;
    flag_we   = 1'b0;
    flag_val  = alu_flag;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RDX;
      end
      ST_RDX: begin
        rf_idx    = (cmd_r == CMD_REG_RD) ? addr_r[3:0] : op_x;
        state_nxt = ST_RDY;
      end
      ST_RDY: begin
        rf_idx    = (op_hi == OP_JPV0) ? 4'd0 : op_y;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        if (cmd_r == CMD_MEM_WR) begin
          mem_we    = 1'b1;
          mem_waddr = addr_r;
          mem_wdata = wdata_r;
        end else if (cmd_r == CMD_EXEC) begin
          case (op_hi)
            OP_LDI: begin
              reg_we    = 1'b1;
              reg_wdata = op_kk;
            end
            OP_ADDI: begin
              alu_op = ALU_ADD;
              alu_b  = op_kk;
              reg_we = 1'b1;
            end
            OP_ALU: begin
              case (op_n)
                SUB_MOV: begin
                  alu_op = ALU_PASS;
                  reg_we = 1'b1;
                end
                SUB_OR: begin
                  alu_op = ALU_OR;
                  reg_we = 1'b1;
                end
                SUB_AND: begin
                  alu_op = ALU_AND;
                  reg_we = 1'b1;
                end
                SUB_XOR: begin
                  alu_op = ALU_XOR;
                  reg_we = 1'b1;
                end
                SUB_ADD: begin
                  alu_op  = ALU_ADD;
                  reg_we  = 1'b1;
                  flag_we = 1'b1;
                end
                SUB_SUB: begin
                  alu_op  = ALU_SUB;
                  reg_we  = 1'b1;
                  flag_we = 1'b1;
                end
                SUB_SHR: begin
                  alu_op  = ALU_SHR;
                  reg_we  = 1'b1;
                  flag_we = 1'b1;
                end
                SUB_SBN: begin
                  alu_op  = ALU_SUB;
                  alu_a   = vy_r;
                  alu_b   = vx_r;
                  reg_we  = 1'b1;
                  flag_we = 1'b1;
                end
                SUB_SHL: begin
                  alu_op  = ALU_SHL;
                  reg_we  = 1'b1;
                  flag_we = 1'b1;
                end
                default: reg_we = 1'b0;
              endcase
            end
            OP_RND: begin
              reg_we    = 1'b1;
              reg_wdata = rnd_r & op_kk;
            end
            OP_DRW: begin
              if (op_n == 4'd0) begin
                flag_we  = 1'b1;
                flag_val = 1'b0;
              end else begin
                state_nxt = ST_DRAW_RD;
              end
            end
            OP_MISC: begin
              case (op_kk)
                KK_GDT: begin
                  reg_we    = 1'b1;
                  reg_wdata = dt_r;
                end
                KK_WKEY: begin
                  reg_we    = key_any;
                  reg_wdata = {4'd0, key_idx};
                end
                KK_BCD:  state_nxt = ST_BCD;
                KK_STR:  state_nxt = ST_STORE;
                KK_LDR:  state_nxt = ST_LOAD_RD;
                default: reg_we = 1'b0;
              endcase
            end
            default: reg_we = 1'b0;
          endcase
        end
      end
      ST_DRAW_RD: begin
        mem_raddr = i_plus_cnt;
        fb_raddr  = draw_row;
        state_nxt = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        fb_we = 1'b1;
        if (cnt_r == op_n - 4'd1) begin
          flag_we   = 1'b1;
          flag_val  = hit_r | (|(row_cur & sprite_mask));
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DRAW_RD;
        end
      end
      ST_BCD: begin
        mem_we = 1'b1;
        case (cnt_r[1:0])
          2'd0:    mem_wdata = {4'd0, bcd[11:8]};
          2'd1:    mem_wdata = {4'd0, bcd[7:4]};
          default: mem_wdata = {4'd0, bcd[3:0]};
        endcase
        if (cnt_r == 4'd2) state_nxt = ST_DONE;
      end
      ST_STORE: begin
        rf_idx    = cnt_r;
        mem_we    = 1'b1;
        mem_wdata = rf_rd;
        if (cnt_r == op_x) state_nxt = ST_DONE;
      end
      ST_LOAD_RD: begin
        mem_raddr = i_plus_cnt;
        state_nxt = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        reg_we    = 1'b1;
        reg_widx  = cnt_r;
        reg_wdata = mem_rdata;
        state_nxt = (cnt_r == op_x) ? ST_DONE : ST_LOAD_RD;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) regs_r[k] <= 8'd0;
      pc_r        <= AddrW'(12'h200);
      i_r         <= '0;
      sp_r        <= 4'd0;
      dt_r        <= 8'd0;
      st_r        <= 8'd0;
      fb_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the flag wins over a result written to vf
      if (reg_we && !(flag_we && reg_widx == 4'd15)) regs_r[reg_widx] <= reg_wdata;
      if (flag_we) regs_r[15] <= {7'd0, flag_val};
      if (fb_we) fb_valid_r[fb_waddr] <= 1'b1;
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_data.cmd;
            op_r    <= in_data.instruction;
            addr_r  <= in_data.address;
            wdata_r <= in_data.write_data;
            keys_r  <= in_data.key_state;
            rnd_r   <= in_data.random_byte;
            rd_r    <= 8'd0;
            row_r   <= 64'd0;
            wait_r  <= 1'b0;
          end
        end
        ST_RDX: begin
          vx_r <= rf_rd;
        end
        ST_RDY: begin
          vy_r <= rf_rd;
          if (cmd_r == CMD_MEM_RD) rd_r <= mem_rdata;
          if (cmd_r == CMD_ROW_RD) begin
            row_r <= fb_valid_r[addr_r[RowW-1:0]] ? fb_rdata : 64'd0;
          end
        end
        ST_EXEC: begin
          cnt_r <= 4'd0;
          hit_r <= 1'b0;
          case (cmd_r)
            CMD_TICK: begin
              if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
              if (st_r != 8'd0) st_r <= st_r - 8'd1;
            end
            CMD_REG_RD: rd_r <= vx_r;
            CMD_EXEC: begin
              pc_r <= pc_exec;
              case (op_hi)
                OP_SYS: begin
                  if (op_r == INS_CLS) fb_valid_r <= '0;
                  if (op_r == INS_RET) sp_r <= sp_r - 4'd1;
                end
                OP_CALL: begin
                  stk_r[sp_r] <= pc_inc;
                  sp_r        <= sp_r + 4'd1;
                end
                OP_LDIX: i_r <= op_nnn;
                OP_MISC: begin
                  case (op_kk)
                    KK_WKEY: wait_r <= !key_any;
                    KK_SDT:  dt_r <= vx_r;
                    KK_SST:  st_r <= vx_r;
                    KK_ADDI: i_r <= i_r + {4'd0, vx_r};
                    KK_FONT: i_r <= {6'd0, vx_r[3:0], 2'b00} + {8'd0, vx_r[3:0]};
                    default: wait_r <= 1'b0;
                  endcase
                end
                default: wait_r <= 1'b0;
              endcase
            end
            default: wait_r <= 1'b0;
          endcase
        end
        ST_DRAW_WR: begin
          hit_r <= hit_r | (|(row_cur & sprite_mask));
          cnt_r <= cnt_r + 4'd1;
        end
        ST_BCD, ST_STORE, ST_LOAD_WR: begin
          cnt_r <= cnt_r + 4'd1;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.program_counter <= pc_r;
            out_data_r.index_value     <= i_r;
            out_data_r.read_data       <= rd_r;
            out_data_r.display_row     <= row_r;
            out_data_r.waiting_for_key <= wait_r;
            out_data_r.sound_active    <= (st_r != 8'd0);
          end
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // handshake and result outputs
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
